@@ rtl/sse_pkg.sv @@
// Shared types and constants for the shaker sort engine.
// Used by the interfaces, controller, datapath, top level and checker.
`timescale 1ns / 1ps

package sse_pkg;

  localparam int DATA_W      = 32;
  localparam int MAX_LEN_DEF = 64;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_F_START,
    ST_F_FIRST,
    ST_F_RUN,
    ST_F_END,
    ST_B_START,
    ST_B_FIRST,
    ST_B_RUN,
    ST_B_END,
    ST_E_READ,
    ST_E_WAIT
  } state_t;

  // Source of the store write data
  typedef enum logic [1:0] {
    WSEL_IN,
    WSEL_MOVE,
    WSEL_CARRY
  } wsel_t;

  // Update of the running carry element
  typedef enum logic [1:0] {
    CARRY_HOLD,
    CARRY_LOAD,
    CARRY_EXTREME
  } carry_op_t;

  typedef struct packed {
    logic      rd_en;
    logic      wr_en;
    wsel_t     wr_sel;
    carry_op_t carry_op;
    logic      backward;
    logic      out_load;
    logic      out_last;
    logic      out_ovf;
  } cmd_t;

  typedef struct packed {
    logic gt;
    logic out_free;
  } status_t;

endpackage

@@ rtl/sse_if.sv @@
// Valid/ready stream interfaces for input items and sorted results.
// Depends on sse_pkg for the data width.
`timescale 1ns / 1ps

interface sse_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sse_pkg::DATA_W-1:0] value;
  logic                             is_last;

  modport source(output valid, value, is_last, input ready);
  modport sink(input valid, value, is_last, output ready);
endinterface

interface sse_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sse_pkg::DATA_W-1:0] sorted_value;
  logic                             is_last_res;
  logic                             overflow;

  modport source(output valid, sorted_value, is_last_res, overflow, input ready);
  modport sink(input valid, sorted_value, is_last_res, overflow, output ready);
endinterface

@@ rtl/shaker_sort_engine_top.sv @@
// Shaker sort engine: each list is loaded beat by beat, sorted by alternating
// forward and backward passes and then emitted result by result, one list at
// a time. The sort rate is set by the single compare-and-swap unit on one store
// read port and one write port.
// Reset is synchronous and clears the controller and the output valid; the
// element store is not cleared and holds whatever was last written.
`timescale 1ns / 1ps

module shaker_sort_engine_top #(
  parameter int MAX_LEN = sse_pkg::MAX_LEN_DEF
) (
  input logic       clk,
  input logic       rst,
  sse_in_if.sink    items,
  sse_out_if.source results
);

  localparam int AW = $clog2(MAX_LEN);

  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t status;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;

  // Controller: owns count, bounds, scan position and the pass sequence.
  // Input beats are taken only while loading; once the last result sits in
  // the output register the controller returns to loading, so the next list
  // can start before that result is taken.
  sse_ctrl #(
    .MAX_LEN(MAX_LEN)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_is_last(items.is_last),
    .in_ready  (items.ready),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // Datapath: the store, the carry element that bubbles through each pass,
  // and the result register that decouples the output handshake.
  sse_datapath #(
    .MAX_LEN(MAX_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .in_value (items.value),
    .status   (status),
    .out_valid(results.valid),
    .out_ready(results.ready),
    .out_value(results.sorted_value),
    .out_last (results.is_last_res),
    .out_ovf  (results.overflow)
  );

endmodule

@@ rtl/sse_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/sse_datapath.sv @@
// Datapath: element store, running carry with compare, output register.
// Depends on sse_pkg and sse_ram; driven by commands from sse_ctrl.
`timescale 1ns / 1ps

module sse_datapath #(
  parameter int MAX_LEN = sse_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sse_pkg::cmd_t                     cmd,
  input  logic [$clog2(MAX_LEN)-1:0]        wr_addr,
  input  logic [$clog2(MAX_LEN)-1:0]        rd_addr,
  input  logic signed [sse_pkg::DATA_W-1:0] in_value,
  output sse_pkg::status_t                  status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [sse_pkg::DATA_W-1:0] out_value,
  output logic                              out_last,
  output logic                              out_ovf
);

  localparam int AW = $clog2(MAX_LEN);

  logic signed [sse_pkg::DATA_W-1:0] rd_data;
  logic signed [sse_pkg::DATA_W-1:0] carry;
  logic signed [sse_pkg::DATA_W-1:0] wr_data;
  logic                              gt;

  sse_ram #(
    .WIDTH(sse_pkg::DATA_W),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk    (clk),
    .wr_en  (cmd.wr_en),
    .wr_addr(wr_addr[AW-1:0]),
    .wr_data(wr_data),
    .rd_en  (cmd.rd_en),
    .rd_addr(rd_addr[AW-1:0]),
    .rd_data(rd_data)
  );

  // Forward passes carry the maximum upward, backward passes the minimum down
  assign gt = cmd.backward ? (rd_data > carry) : (carry > rd_data);

  always_comb begin
    unique case (cmd.wr_sel)
      sse_pkg::WSEL_IN:    wr_data = in_value;
      sse_pkg::WSEL_MOVE:  wr_data = gt ? rd_data : carry;
      sse_pkg::WSEL_CARRY: wr_data = carry;
      default:             wr_data = carry;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.carry_op)
      sse_pkg::CARRY_LOAD:    carry <= rd_data;
      sse_pkg::CARRY_EXTREME: carry <= gt ? carry : rd_data;
      default:                carry <= carry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value <= rd_data;
      out_last  <= cmd.out_last;
      out_ovf   <= cmd.out_ovf;
    end
  end

  assign status.gt       = gt;
  assign status.out_free = !out_valid || out_ready;

endmodule

@@ rtl/sse_ctrl.sv @@
// Controller: load, forward/backward pass sequencing and emission.
// Depends on sse_pkg; drives sse_datapath through cmd and addresses.
`timescale 1ns / 1ps

module sse_ctrl #(
  parameter int MAX_LEN = sse_pkg::MAX_LEN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_is_last,
  output logic                       in_ready,
  input  sse_pkg::status_t           status,
  output sse_pkg::cmd_t              cmd,
  output logic [$clog2(MAX_LEN)-1:0] wr_addr,
  output logic [$clog2(MAX_LEN)-1:0] rd_addr
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEN);

  sse_pkg::state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] hi, hi_next;
  logic [AW-1:0] lo, lo_next;
  logic [AW-1:0] pos, pos_next;
  logic [AW-1:0] last_swap, last_swap_next;
  logic          swapped, swapped_next;
  logic          ovf, ovf_next;
  logic          fin;
  logic [CW-1:0] top;

  assign fin = (CW'(pos) + CW'(1)) == cnt;
  assign top = hi - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sse_pkg::ST_LOAD;
      cnt       <= '0;
      hi        <= '0;
      lo        <= '0;
      pos       <= '0;
      last_swap <= '0;
      swapped   <= 1'b0;
      ovf       <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      hi        <= hi_next;
      lo        <= lo_next;
      pos       <= pos_next;
      last_swap <= last_swap_next;
      swapped   <= swapped_next;
      ovf       <= ovf_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    hi_next        = hi;
    lo_next        = lo;
    pos_next       = pos;
    last_swap_next = last_swap;
    swapped_next   = swapped;
    ovf_next       = ovf;
    in_ready       = 1'b0;
    wr_addr        = pos;
    rd_addr        = pos;
    cmd            = '{rd_en: 1'b0, wr_en: 1'b0, wr_sel: sse_pkg::WSEL_CARRY,
                       carry_op: sse_pkg::CARRY_HOLD, backward: 1'b0,
                       out_load: 1'b0, out_last: 1'b0, out_ovf: 1'b0};

    unique case (state)
      sse_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (cnt < MAX_CNT) begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = sse_pkg::WSEL_IN;
            wr_addr    = cnt[AW-1:0];
            cnt_next   = cnt + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (in_is_last) begin
            lo_next    = '0;
            hi_next    = cnt_next;
            state_next = sse_pkg::ST_F_START;
          end
        end
      end

      sse_pkg::ST_F_START: begin
        swapped_next = 1'b0;
        if (hi < CW'(lo) + CW'(2)) begin
          pos_next   = '0;
          state_next = sse_pkg::ST_E_READ;
        end else begin
          cmd.rd_en  = 1'b1;
          rd_addr    = lo;
          pos_next   = lo + AW'(1);
          state_next = sse_pkg::ST_F_FIRST;
        end
      end

      sse_pkg::ST_F_FIRST: begin
        cmd.carry_op = sse_pkg::CARRY_LOAD;
        cmd.rd_en    = 1'b1;
        rd_addr      = pos;
        state_next   = sse_pkg::ST_F_RUN;
      end

      sse_pkg::ST_F_RUN: begin
        cmd.carry_op = sse_pkg::CARRY_EXTREME;
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = sse_pkg::WSEL_MOVE;
        wr_addr      = pos - AW'(1);
        if (status.gt) begin
          swapped_next = 1'b1;
        end
        if (CW'(pos) + CW'(1) < hi) begin
          cmd.rd_en = 1'b1;
          rd_addr   = pos + AW'(1);
          pos_next  = pos + AW'(1);
        end else begin
          state_next = sse_pkg::ST_F_END;
        end
      end

      sse_pkg::ST_F_END: begin
        cmd.wr_en = 1'b1;
        wr_addr   = pos;
        hi_next   = top;
        if (swapped) begin
          state_next = sse_pkg::ST_B_START;
        end else begin
          pos_next   = '0;
          state_next = sse_pkg::ST_E_READ;
        end
      end

      sse_pkg::ST_B_START: begin
        swapped_next = 1'b0;
        if (top > CW'(lo)) begin
          cmd.rd_en  = 1'b1;
          rd_addr    = top[AW-1:0];
          pos_next   = top[AW-1:0] - AW'(1);
          state_next = sse_pkg::ST_B_FIRST;
        end else begin
          pos_next   = '0;
          state_next = sse_pkg::ST_E_READ;
        end
      end

      sse_pkg::ST_B_FIRST: begin
        cmd.carry_op = sse_pkg::CARRY_LOAD;
        cmd.backward = 1'b1;
        cmd.rd_en    = 1'b1;
        rd_addr      = pos;
        state_next   = sse_pkg::ST_B_RUN;
      end

      sse_pkg::ST_B_RUN: begin
        cmd.carry_op = sse_pkg::CARRY_EXTREME;
        cmd.backward = 1'b1;
        cmd.wr_en    = 1'b1;
        cmd.wr_sel   = sse_pkg::WSEL_MOVE;
        wr_addr      = pos + AW'(1);
        if (status.gt) begin
          swapped_next   = 1'b1;
          last_swap_next = pos + AW'(1);
        end
        if (pos > lo) begin
          cmd.rd_en = 1'b1;
          rd_addr   = pos - AW'(1);
          pos_next  = pos - AW'(1);
        end else begin
          state_next = sse_pkg::ST_B_END;
        end
      end

      sse_pkg::ST_B_END: begin
        cmd.wr_en = 1'b1;
        wr_addr   = pos;
        lo_next   = last_swap;
        if (swapped) begin
          state_next = sse_pkg::ST_F_START;
        end else begin
          pos_next   = '0;
          state_next = sse_pkg::ST_E_READ;
        end
      end

      sse_pkg::ST_E_READ: begin
        if (status.out_free) begin
          cmd.rd_en  = 1'b1;
          rd_addr    = pos;
          state_next = sse_pkg::ST_E_WAIT;
        end
      end

      sse_pkg::ST_E_WAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_last = fin;
        cmd.out_ovf  = fin && ovf;
        if (fin) begin
          cnt_next       = '0;
          hi_next        = '0;
          lo_next        = '0;
          pos_next       = '0;
          last_swap_next = '0;
          swapped_next   = 1'b0;
          ovf_next       = 1'b0;
          state_next     = sse_pkg::ST_LOAD;
        end else begin
          pos_next   = pos + AW'(1);
          state_next = sse_pkg::ST_E_READ;
        end
      end

      default: begin
        state_next = sse_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

@@ rtl/sse_checker.sv @@
// Port-level checks for the shaker sort engine, bound to the top level.
// Depends on sse_pkg for the data width.
`timescale 1ns / 1ps

module sse_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sse_pkg::DATA_W-1:0] out_value,
  input logic                              out_last,
  input logic                              out_ovf
);

  logic                              in_list;
  logic signed [sse_pkg::DATA_W-1:0] prev_value;
  logic                              out_beat;

  assign out_beat = out_valid && out_ready;

  // Track the previous result beat of the current list
  always_ff @(posedge clk) begin
    if (rst) begin
      in_list <= 1'b0;
    end else if (out_beat) begin
      in_list <= !out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_value <= out_value;
    end
  end

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    out_beat && in_list |-> prev_value <= out_value)
    else $error("results not in ascending order");

  a_ovf_on_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ovf |-> out_last)
    else $error("overflow shown on a result that is not last");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before the beat was taken");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind shaker_sort_engine_top sse_checker u_sse_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_value(results.sorted_value),
  .out_last (results.is_last_res),
  .out_ovf  (results.overflow)
);
